### rtl/core/upp_pkg.sv
// Unicycle pose predictor: shared types, constants and rounding helpers.
// No dependencies; used by every file in rtl/core but upp_delay.
package upp_pkg;

	localparam int DIV_BITS = 48;
	localparam int LATENCY = 53;
	localparam logic [30:0] PHASE_SCALE = 31'd683565276;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	localparam logic [29:0] ATAN_PHASE [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
	};

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_theta;
		logic signed [31:0] speed;
		logic signed [31:0] turn_rate;
		logic [15:0]        time_step;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] next_x;
		logic signed [31:0] next_y;
		logic signed [31:0] next_theta;
		logic               went_straight;
	} out_word_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               flip;
	} cordic_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [47:0] num;
		logic [47:0] quo;
		logic [31:0] den;
		logic        neg;
	} div_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] th;
		logic signed [31:0] v;
		logic [15:0]        dt;
		logic               straight;
	} side_t;

	typedef struct packed {
		logic signed [31:0] s0;
		logic signed [31:0] c0;
		logic signed [31:0] s1;
		logic signed [31:0] c1;
	} trig_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [65:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd536870912;
		return {{32{t[63]}}, t[63:30]};
	endfunction

	function automatic logic signed [65:0] rnd16(input logic signed [48:0] p);
		logic signed [48:0] t;
		t = p + 49'sd32768;
		return {{33{t[48]}}, t[48:16]};
	endfunction

	function automatic logic signed [65:0] ext32(input logic signed [31:0] v);
		return {{34{v[31]}}, v};
	endfunction

	function automatic cordic_t reduce(input logic [31:0] phase);
		cordic_t     c;
		logic [31:0] q;
		logic [31:0] p;
		q = phase + 32'h40000000;
		p = q[31] ? phase + 32'h80000000 : phase;
		c.x = CORDIC_GAIN;
		c.y = '0;
		c.z = {{2{p[31]}}, p};
		c.flip = q[31];
		return c;
	endfunction

	function automatic logic signed [31:0] finish(input logic signed [33:0] v, input logic flip);
		logic signed [33:0] c;
		c = v;
		if (v > ONE_Q30) begin
			c = ONE_Q30;
		end else if (v < -ONE_Q30) begin
			c = -ONE_Q30;
		end
		if (flip) begin
			c = -c;
		end
		return c[31:0];
	endfunction

endpackage

### rtl/core/upp_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with a fixed shift.
// Depends on upp_pkg.
module upp_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  upp_pkg::cordic_t  din,
	output upp_pkg::cordic_t  dout
);
	localparam logic signed [33:0] ANG = {4'b0, upp_pkg::ATAN_PHASE[SHIFT]};

	upp_pkg::cordic_t nxt;

	always_comb begin
		nxt.flip = din.flip;
		if (!din.z[33]) begin
			nxt.x = din.x - (din.y >>> SHIFT);
			nxt.y = din.y + (din.x >>> SHIFT);
			nxt.z = din.z - ANG;
		end else begin
			nxt.x = din.x + (din.y >>> SHIFT);
			nxt.y = din.y - (din.x >>> SHIFT);
			nxt.z = din.z + ANG;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

### rtl/core/upp_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on upp_pkg.
module upp_div_cell (
	input  logic           clk,
	input  upp_pkg::div_t  din,
	output upp_pkg::div_t  dout
);
	logic [32:0]    trial;
	logic           ge;
	upp_pkg::div_t  nxt;

	always_comb begin
		trial = {din.rem[31:0], din.num[47]};
		ge = trial >= {1'b0, din.den};
		nxt.rem = ge ? trial - {1'b0, din.den} : trial;
		nxt.num = {din.num[46:0], 1'b0};
		nxt.quo = {din.quo[46:0], ge};
		nxt.den = din.den;
		nxt.neg = din.neg;
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

### rtl/core/upp_delay.sv
// Fixed-length register delay line for side data.
// No dependencies.
module upp_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		tap_q[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[DEPTH-1];
endmodule

### rtl/core/unicycle_pose_predict.sv
// Unicycle pose predictor top level: CORDIC and divider cell chains, output math.
// Depends on upp_pkg, upp_cordic_cell, upp_div_cell, upp_delay.
//
//  port        dir  kind     meaning
//  start/item  in   command  pose, speed, turn rate, time step
//  busy        out  status   always low, one word per cycle
//  done/result out  strobe   predicted pose, one cycle wide
//  cfg_we/data in   write    omega_epsilon
//
// One word accepted per cycle; done strobes each result, in the order of the starts.
// Latency is set by the 48-cell divider chain; the CORDIC chains are padded to match.
// arst_n clears the valid pipeline and sets omega_epsilon to 1.
// The receiver cannot stall; results are strobed once.
module unicycle_pose_predict #(
	parameter int CORDIC_STAGES = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  upp_pkg::in_word_t  item,
	output logic               done,
	output upp_pkg::out_word_t result,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data
);
	localparam int SIDE_W = $bits(upp_pkg::side_t);
	localparam int TRIG_W = $bits(upp_pkg::trig_t);

	logic [15:0]                 eps_q;
	logic [upp_pkg::LATENCY-1:0] vld_q;

	upp_pkg::in_word_t  item_s1;
	logic               straight_s1;
	logic signed [48:0] wdt_s1;
	logic [31:0]        ph0_s1;
	logic signed [31:0] nth_s2;
	upp_pkg::cordic_t   cord0_s2, cord0_s3, cord0_s4, cord1_s4;
	logic [31:0]        ph1_s3;
	upp_pkg::cordic_t   ch0 [CORDIC_STAGES+1];
	upp_pkg::cordic_t   ch1 [CORDIC_STAGES+1];
	upp_pkg::div_t      dv [upp_pkg::DIV_BITS+1];
	upp_pkg::trig_t     trig_q, trig_s50;
	upp_pkg::side_t     side_s1, side_s50, side_s51, side_s52;
	logic signed [31:0] nth_s50, nth_s51, nth_s52;
	logic signed [31:0] r_s50;
	logic signed [63:0] ps0_s51, pc0_s51, ps1_s51, pc1_s51;
	logic signed [31:0] vc_s52, vs_s52, ax_s52, ay_s52;
	upp_pkg::out_word_t res_s53;

	logic [32:0]        aw;
	logic               straight_in;
	logic signed [62:0] ph0_prod, ph1_prod;
	logic signed [31:0] mul_a;
	logic signed [48:0] vcdt, vsdt;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_data;
			end
			vld_q <= {vld_q[upp_pkg::LATENCY-2:0], start && !busy};
		end
	end

	always_comb begin
		aw = item.turn_rate[31] ? -{1'b1, item.turn_rate} : {1'b0, item.turn_rate};
		straight_in = (item.turn_rate == 32'sd0) || (aw < {17'b0, eps_q});
		ph0_prod = item.pose_theta * $signed({1'b0, upp_pkg::PHASE_SCALE});
		ph1_prod = nth_s2 * $signed({1'b0, upp_pkg::PHASE_SCALE});
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		straight_s1 <= straight_in;
		wdt_s1 <= item.turn_rate * $signed({1'b0, item.time_step});
		ph0_s1 <= ph0_prod[47:16];
		nth_s2 <= upp_pkg::sat32(upp_pkg::ext32(item_s1.pose_theta) + upp_pkg::rnd16(wdt_s1));
		cord0_s2 <= upp_pkg::reduce(ph0_s1);
		cord0_s3 <= cord0_s2;
		cord0_s4 <= cord0_s3;
		ph1_s3 <= ph1_prod[47:16];
		cord1_s4 <= upp_pkg::reduce(ph1_s3);
	end

	assign ch0[0] = cord0_s4;
	assign ch1[0] = cord1_s4;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		upp_cordic_cell #(.SHIFT(k)) u_c0 (.clk(clk), .din(ch0[k]), .dout(ch0[k+1]));
		upp_cordic_cell #(.SHIFT(k)) u_c1 (.clk(clk), .din(ch1[k]), .dout(ch1[k+1]));
	end

	always_ff @(posedge clk) begin
		trig_q.s0 <= upp_pkg::finish(ch0[CORDIC_STAGES].y, ch0[CORDIC_STAGES].flip);
		trig_q.c0 <= upp_pkg::finish(ch0[CORDIC_STAGES].x, ch0[CORDIC_STAGES].flip);
		trig_q.s1 <= upp_pkg::finish(ch1[CORDIC_STAGES].y, ch1[CORDIC_STAGES].flip);
		trig_q.c1 <= upp_pkg::finish(ch1[CORDIC_STAGES].x, ch1[CORDIC_STAGES].flip);
	end

	upp_delay #(.WIDTH(TRIG_W), .DEPTH(45 - CORDIC_STAGES)) u_trig_dly (
		.clk(clk), .din(trig_q), .dout(trig_s50)
	);

	always_comb begin
		side_s1.x = item_s1.pose_x;
		side_s1.y = item_s1.pose_y;
		side_s1.th = item_s1.pose_theta;
		side_s1.v = item_s1.speed;
		side_s1.dt = item_s1.time_step;
		side_s1.straight = straight_s1;
		dv[0].rem = '0;
		dv[0].num = {(item_s1.speed[31] ? -item_s1.speed : item_s1.speed), 16'b0};
		dv[0].quo = '0;
		dv[0].den = item_s1.turn_rate[31] ? -item_s1.turn_rate : item_s1.turn_rate;
		dv[0].neg = item_s1.speed[31] ^ item_s1.turn_rate[31];
	end

	upp_delay #(.WIDTH(SIDE_W), .DEPTH(49)) u_side_dly (
		.clk(clk), .din(side_s1), .dout(side_s50)
	);
	upp_delay #(.WIDTH(32), .DEPTH(48)) u_nth_dly (
		.clk(clk), .din(nth_s2), .dout(nth_s50)
	);

	for (genvar k = 0; k < upp_pkg::DIV_BITS; k++) begin : g_div
		upp_div_cell u_d (.clk(clk), .din(dv[k]), .dout(dv[k+1]));
	end

	always_ff @(posedge clk) begin
		if (dv[upp_pkg::DIV_BITS].neg) begin
			if (dv[upp_pkg::DIV_BITS].quo > 48'h80000000) begin
				r_s50 <= 32'sh80000000;
			end else begin
				r_s50 <= -dv[upp_pkg::DIV_BITS].quo[31:0];
			end
		end else begin
			if (dv[upp_pkg::DIV_BITS].quo > 48'h7fffffff) begin
				r_s50 <= 32'sh7fffffff;
			end else begin
				r_s50 <= dv[upp_pkg::DIV_BITS].quo[31:0];
			end
		end
	end

	assign mul_a = side_s50.straight ? side_s50.v : r_s50;

	always_ff @(posedge clk) begin
		ps0_s51 <= mul_a * trig_s50.s0;
		pc0_s51 <= mul_a * trig_s50.c0;
		ps1_s51 <= mul_a * trig_s50.s1;
		pc1_s51 <= mul_a * trig_s50.c1;
		side_s51 <= side_s50;
		nth_s51 <= nth_s50;
		vc_s52 <= upp_pkg::sat32(upp_pkg::rnd30(pc0_s51));
		vs_s52 <= upp_pkg::sat32(upp_pkg::rnd30(ps0_s51));
		ax_s52 <= upp_pkg::sat32(upp_pkg::ext32(side_s51.x) - upp_pkg::rnd30(ps0_s51)
			+ upp_pkg::rnd30(ps1_s51));
		ay_s52 <= upp_pkg::sat32(upp_pkg::ext32(side_s51.y) + upp_pkg::rnd30(pc0_s51)
			- upp_pkg::rnd30(pc1_s51));
		side_s52 <= side_s51;
		nth_s52 <= nth_s51;
	end

	assign vcdt = vc_s52 * $signed({1'b0, side_s52.dt});
	assign vsdt = vs_s52 * $signed({1'b0, side_s52.dt});

	always_ff @(posedge clk) begin
		if (side_s52.straight) begin
			res_s53.next_x <= upp_pkg::sat32(upp_pkg::ext32(side_s52.x) + upp_pkg::rnd16(vcdt));
			res_s53.next_y <= upp_pkg::sat32(upp_pkg::ext32(side_s52.y) + upp_pkg::rnd16(vsdt));
			res_s53.next_theta <= side_s52.th;
		end else begin
			res_s53.next_x <= ax_s52;
			res_s53.next_y <= ay_s52;
			res_s53.next_theta <= nth_s52;
		end
		res_s53.went_straight <= side_s52.straight;
	end

	assign done = vld_q[upp_pkg::LATENCY-1];
	assign result = res_s53;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, upp_pkg::LATENCY)) else $error("result without command");
	a_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(start && item.turn_rate == 32'sd0) |=> straight_s1) else $error("zero rate not straight");
	a_straight_theta: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[upp_pkg::LATENCY-2] && side_s52.straight) |=> result.went_straight)
		else $error("straight flag lost");
`endif
endmodule

### sim/upp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the unicycle pose predictor: watches the command, result and register ports,
// predicts each result word in fixed point and compares it field by field. Depends on upp_pkg.
module upp_checker #(
	parameter int CORDIC_STAGES = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  upp_pkg::in_word_t  item,
	input  logic               done,
	input  upp_pkg::out_word_t result,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 checked,
	output int                 arcs
);
	import upp_pkg::*;

	localparam longint ATAN_TBL [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	logic [15:0] eps_q;
	out_word_t   pose_q[$];

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint clip_unit(input longint v);
		if (v > 64'sd1073741824) begin
			return 64'sd1073741824;
		end else if (v < -64'sd1073741824) begin
			return -64'sd1073741824;
		end
		return v;
	endfunction

	function automatic longint round_q(input longint v, input int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic void rotate(input longint angle, output longint s, output longint c);
		longint unsigned prod;
		logic [31:0]     ph;
		logic [31:0]     q;
		logic            flip;
		longint          x, y, z, nx;
		prod = $unsigned(angle) * 64'd683565276;
		ph = prod[47:16];
		q = ph + 32'h40000000;
		flip = q[31];
		if (flip) begin
			ph = ph + 32'h80000000;
		end
		z = longint'($signed(ph));
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_TBL[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_TBL[i];
			end
			x = nx;
		end
		x = clip_unit(x);
		y = clip_unit(y);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic out_word_t predict_pose(input in_word_t w, input logic [15:0] eps);
		out_word_t o;
		longint    x, y, th, v, om, dt, aom, s0, c0, s1, c1, nx, ny, nth, r, vc, vs;
		logic      straight;
		x = w.pose_x;
		y = w.pose_y;
		th = w.pose_theta;
		v = w.speed;
		om = w.turn_rate;
		dt = longint'(w.time_step);
		aom = om < 0 ? -om : om;
		straight = (om == 0) || (aom < longint'(eps));
		rotate(th, s0, c0);
		if (straight) begin
			vc = clip32(round_q(v * c0, 30));
			vs = clip32(round_q(v * s0, 30));
			nx = clip32(x + round_q(vc * dt, 16));
			ny = clip32(y + round_q(vs * dt, 16));
			nth = th;
		end else begin
			r = clip32((v * 65536) / om);
			nth = clip32(th + round_q(om * dt, 16));
			rotate(nth, s1, c1);
			nx = clip32(x - round_q(r * s0, 30) + round_q(r * s1, 30));
			ny = clip32(y + round_q(r * c0, 30) - round_q(r * c1, 30));
		end
		o.next_x = nx[31:0];
		o.next_y = ny[31:0];
		o.next_theta = nth[31:0];
		o.went_straight = straight;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
			errors <= 0;
			checked <= 0;
			arcs <= 0;
			pending <= 0;
			pose_q.delete();
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_data;
			end
			if (start && !busy) begin
				pose_q.push_back(predict_pose(item, eps_q));
			end
			if (done) begin
				if (pose_q.size() == 0) begin
					$error("result word with nothing expected");
					errors <= errors + 1;
				end else begin
					out_word_t e;
					int        bad;
					e = pose_q.pop_front();
					bad = 0;
					checked <= checked + 1;
					if (!e.went_straight) begin
						arcs <= arcs + 1;
					end
					if (result.next_x !== e.next_x) begin
						$error("next_x: expected %0d, got %0d", e.next_x, result.next_x);
						bad = bad + 1;
					end
					if (result.next_y !== e.next_y) begin
						$error("next_y: expected %0d, got %0d", e.next_y, result.next_y);
						bad = bad + 1;
					end
					if (result.next_theta !== e.next_theta) begin
						$error("next_theta: expected %0d, got %0d", e.next_theta,
							result.next_theta);
						bad = bad + 1;
					end
					if (result.went_straight !== e.went_straight) begin
						$error("went_straight: expected %0b, got %0b", e.went_straight,
							result.went_straight);
						bad = bad + 1;
					end
					errors <= errors + bad;
				end
			end
			pending <= pose_q.size();
		end
	end

endmodule

### sim/tb_unicycle_pose_predict.sv
`timescale 1ns / 1ps
// Testbench top for unicycle_pose_predict: clock, reset, register writes and command words.
// Depends on upp_pkg, the block and upp_checker, which does all prediction and comparison.
module tb_unicycle_pose_predict;
	import upp_pkg::*;

	localparam int WATCH_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    item;
	logic        done;
	out_word_t   result;
	logic        cfg_we;
	logic [15:0] cfg_data;
	int          errors, pending, checked, arcs;
	int          quiet;
	int          idle_pct;

	unicycle_pose_predict dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	upp_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked), .arcs(arcs)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet >= WATCH_LIMIT) begin
			$display("tb_unicycle_pose_predict: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic write_eps(input logic [15:0] v);
		start <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_word_t pose_word(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] th, input logic [31:0] v, input logic [31:0] om,
		input logic [15:0] dt);
		in_word_t w;
		w.pose_x = x;
		w.pose_y = y;
		w.pose_theta = th;
		w.speed = v;
		w.turn_rate = om;
		w.time_step = dt;
		return w;
	endfunction

	function automatic logic [31:0] near(input int mag);
		return 32'($signed($urandom_range(2 * mag)) - mag);
	endfunction

	function automatic in_word_t random_word(input logic [15:0] eps);
		in_word_t    w;
		logic [31:0] om;
		case ($urandom_range(7))
			0: om = 32'd0;
			1: om = near(eps + 2);
			2: om = $urandom;
			default: om = near(4 << 16);
		endcase
		if ($urandom_range(3) == 0) begin
			w = pose_word($urandom, $urandom, $urandom, $urandom, om,
				16'($urandom_range(65535)));
		end else begin
			w = pose_word(near(100 << 16), near(100 << 16), near(20 << 16), near(5 << 16),
				om, 16'($urandom_range(65535)));
		end
		return w;
	endfunction

	initial begin
		logic [15:0] eps_list [5];
		int          idle_list [5];
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		quiet = 0;
		eps_list = '{16'd300, 16'd0, 16'd65535, 16'($urandom_range(1, 65534)), 16'd1};
		idle_list = '{0, 62, 12, 0, 62};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_eps(eps_list[0]);
		send_word(pose_word(0, 0, 0, 0, 0, 16'd0));
		send_word(pose_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 16'hffff));
		send_word(pose_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 16'hffff));
		send_word(pose_word(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 0, 16'hffff));
		send_word(pose_word(32'h80000000, 32'h7fffffff, 32'h00030000, 32'h80000000, 0, 16'hffff));
		send_word(pose_word(0, 0, 32'h00010000, 5 << 16, 299, 16'h8000));
		send_word(pose_word(0, 0, 32'h00010000, 5 << 16, -299, 16'h8000));
		send_word(pose_word(0, 0, 32'h00010000, 5 << 16, 300, 16'h8000));
		send_word(pose_word(0, 0, 32'h00010000, 5 << 16, -300, 16'h8000));
		send_word(pose_word(1 << 16, 2 << 16, 32'h0001921f, 1 << 16, 1 << 16, 16'h4000));
		send_word(pose_word(1 << 16, 2 << 16, 32'hfffe6de1, -(1 << 16), -(1 << 16), 16'h4000));
		send_word(pose_word(0, 0, 32'h00032440, 3 << 16, 2 << 16, 16'hffff));
		send_word(pose_word(0, 0, 32'h7ff00000, 3 << 16, 32'h7fffffff, 16'hffff));
		send_word(pose_word(0, 0, 32'h80100000, 3 << 16, 32'h80000000, 16'hffff));
		send_word(pose_word(0, 0, 0, 32'h7fffffff, 1 << 16, 16'd1));
		send_word(pose_word(0, 0, 0, 32'h80000000, 301, 16'd1));
		send_word(pose_word(10 << 16, -(10 << 16), 32'h00048000, 2 << 16, 3 << 16, 16'd0));
		send_word(pose_word(0, 0, 32'h00010000, 32'h00010000, 1, 16'hffff));

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				write_eps(eps_list[ph]);
			end
			idle_pct = idle_list[ph];
			for (int n = 0; n < 270; n++) begin
				send_word(random_word(eps_list[ph]));
			end
		end
		start <= 1'b0;
		idle_pct = 0;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 10) @(negedge clk);
		$display("Covered %0d pose predictions (%0d on arcs) over 5 threshold settings,",
			checked, arcs);
		$display("with zero, extreme and random sender gaps.");
		if (errors == 0) begin
			$display("tb_unicycle_pose_predict: PASS");
		end else begin
			$display("tb_unicycle_pose_predict: FAIL");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/upp_pkg.sv
rtl/core/upp_cordic_cell.sv
rtl/core/upp_div_cell.sv
rtl/core/upp_delay.sv
rtl/core/unicycle_pose_predict.sv
sim/upp_checker.sv
sim/tb_unicycle_pose_predict.sv
